@@ src/pee_pkg.sv @@
`timescale 1ns / 1ps

package pee_pkg;

  // character codes
  localparam logic [7:0] SYM_NUL  = 8'h00;
  localparam logic [7:0] SYM_ZERO = 8'h30;
  localparam logic [7:0] SYM_NINE = 8'h39;
  localparam logic [7:0] SYM_PLUS = 8'h2b;
  localparam logic [7:0] SYM_MUL  = 8'h2a;
  localparam logic [7:0] SYM_DIV  = 8'h2f;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DIV_ZERO   = 2'd1,
    ST_OVERFLOW   = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_expr;
  } in_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         postfix_symbol;
    logic signed [31:0] value;
    logic [1:0]         status;
    logic               last;
  } out_t;

  // request to the shared multiply / divide unit
  typedef struct packed {
    logic start;
    logic is_div;
  } alu_req_t;

endpackage

@@ src/pee_ram.sv @@
`timescale 1ns / 1ps

module pee_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pee_alu.sv @@
`timescale 1ns / 1ps

module pee_alu #(
  parameter int W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pee_pkg::alu_req_t req_i,
  input  logic [W-1:0]      a_i,
  input  logic [W-1:0]      b_i,
  output logic              done_o,
  output logic [W-1:0]      result_o
);
  import pee_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic          busy_q, done_q, div_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  x_q, y_q, acc_q;
  logic [W-1:0]  a_mag, b_mag;
  logic [W:0]    rem_sh, diff;

  assign a_mag  = a_i[W-1] ? (W'(0) - a_i) : a_i;
  assign b_mag  = b_i[W-1] ? (W'(0) - b_i) : b_i;
  assign rem_sh = {acc_q, x_q[W-1]};
  assign diff   = rem_sh - {1'b0, y_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      div_q <= req_i.is_div;
      neg_q <= a_i[W-1] ^ b_i[W-1];
      acc_q <= '0;
      x_q   <= req_i.is_div ? a_mag : a_i;
      y_q   <= req_i.is_div ? b_mag : b_i;
    end else if (busy_q) begin
      if (div_q) begin
        // restoring division, one quotient bit per cycle
        if (!diff[W]) begin
          acc_q <= diff[W-1:0];
          x_q   <= {x_q[W-2:0], 1'b1};
        end else begin
          acc_q <= rem_sh[W-1:0];
          x_q   <= {x_q[W-2:0], 1'b0};
        end
      end else begin
        // shift and add multiply
        if (y_q[0]) begin
          acc_q <= acc_q + x_q;
        end
        x_q <= {x_q[W-2:0], 1'b0};
        y_q <= {1'b0, y_q[W-1:1]};
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = !div_q ? acc_q : (neg_q ? (W'(0) - x_q) : x_q);

endmodule

@@ src/prefix_expression_evaluator_top.sv @@
`timescale 1ns / 1ps

// Prefix expression evaluator. Takes one ASCII symbol per request: digits are
// operands, '+', '*' and '/' their operators, any other non-NUL symbol is
// subtraction. With mode 0 the final item (kind 1, last 1) carries the
// wrapping VALUE_WIDTH-bit value, division truncating toward zero; with
// mode 1 each postfix symbol goes out as a kind 0 item as soon as its place
// is known. The status field of the final item reports divide by zero,
// stack overflow or an incomplete expression; the first error sticks.
// Pending operators live in a STACK_DEPTH-entry single-port-read RAM.
// Steps: an operator or ignored symbol passes through dispatch and final,
// waiting longer while a final item meets a stalled output; a digit passes
// through unwind and check for each stack entry it reduces, and waits on
// each multiply or divide, which run bit-serially in one shared unit. One
// request is worked at a time; a new one is taken as soon as the sequencer
// is back in idle, even while a result waits in the output register.
module prefix_expression_evaluator_top #(
  parameter int STACK_DEPTH = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_data_i,
  input  logic          in_valid,
  output logic          in_stall,
  input  pee_pkg::in_t  in_data_i,
  output logic          out_valid,
  input  logic          out_stall,
  output pee_pkg::out_t out_data_o
);
  import pee_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int LW = $clog2(STACK_DEPTH + 1);
  localparam int EW = VALUE_WIDTH + 3;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_DISPATCH = 7'b0000010,
    S_UNWIND   = 7'b0000100,
    S_CHECK    = 7'b0001000,
    S_ARITH    = 7'b0010000,
    S_FINAL    = 7'b0100000,
    S_SPARE    = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic             mode_q;
  logic [LW-1:0]    level_q, level_d;
  logic             done_q, done_d;
  status_e          err_q, err_d;
  logic [VALUE_WIDTH-1:0] final_q, final_d;
  logic [VALUE_WIDTH-1:0] v_q, v_d;
  logic [7:0]       sym_q;
  logic             end_q;

  logic             out_valid_q;
  out_t             out_q;
  logic             emit;
  out_t             emit_data;
  logic             out_free;

  // stack memory signals
  logic             we, re;
  logic [AW-1:0]    waddr, raddr;
  logic [EW-1:0]    wdata, rdata;
  logic [LW-1:0]    level_m1;
  logic [1:0]       e_op;
  logic             e_left;
  logic [VALUE_WIDTH-1:0] e_val;

  alu_req_t         alu_req;
  logic             alu_done;
  logic [VALUE_WIDTH-1:0] alu_res;

  logic             is_digit;
  op_e              new_op;
  logic [31:0]      val32;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_q != S_IDLE);
  assign out_valid = out_valid_q;
  assign out_data_o = out_q;
  assign out_free  = !out_valid_q || !out_stall;

  assign level_m1 = level_q - 1'b1;
  assign raddr    = level_m1[AW-1:0];
  assign {e_op, e_left, e_val} = rdata;
  assign is_digit = (sym_q >= SYM_ZERO) && (sym_q <= SYM_NINE);

  always_comb begin
    case (sym_q)
      SYM_PLUS: new_op = OP_ADD;
      SYM_MUL:  new_op = OP_MUL;
      SYM_DIV:  new_op = OP_DIV;
      default:  new_op = OP_SUB;
    endcase
  end

  // final value trimmed or widened to the 32-bit output field
  generate
    if (VALUE_WIDTH >= 32) begin : g_wide
      assign val32 = final_q[31:0];
    end else begin : g_narrow
      assign val32 = {{(32 - VALUE_WIDTH){1'b0}}, final_q};
    end
  endgenerate

  pee_ram #(
    .WIDTH (EW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  pee_alu #(
    .W (VALUE_WIDTH)
  ) u_alu (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (alu_req),
    .a_i      (e_val),
    .b_i      (v_q),
    .done_o   (alu_done),
    .result_o (alu_res)
  );

  // sequencer: push operators; for a digit, read the top stack entry, then write it back or pop it
  always_comb begin
    state_d   = state_q;
    level_d   = level_q;
    done_d    = done_q;
    err_d     = err_q;
    final_d   = final_q;
    v_d       = v_q;
    we        = 1'b0;
    waddr     = level_q[AW-1:0];
    wdata     = '0;
    re        = 1'b0;
    emit      = 1'b0;
    emit_data = '0;
    alu_req   = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid) begin
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!done_q && err_q == ST_OK && sym_q != SYM_NUL) begin
          if (is_digit) begin
            v_d = VALUE_WIDTH'(sym_q[3:0]);
            if (mode_q) begin
              emit = 1'b1;
              emit_data.postfix_symbol = sym_q;
              if (out_free) begin
                state_d = S_UNWIND;
              end
            end else begin
              state_d = S_UNWIND;
            end
          end else if (level_q >= LW'(STACK_DEPTH)) begin
            err_d   = ST_OVERFLOW;
            state_d = S_FINAL;
          end else begin
            we      = 1'b1;
            wdata   = {new_op, 1'b0,
                       mode_q ? VALUE_WIDTH'(sym_q) : VALUE_WIDTH'(0)};
            level_d = level_q + 1'b1;
            state_d = S_FINAL;
          end
        end else begin
          state_d = S_FINAL;
        end
      end
      S_UNWIND: begin
        if (level_q == '0) begin
          done_d  = 1'b1;
          final_d = v_q;
          state_d = S_FINAL;
        end else begin
          re      = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!e_left) begin
          // operator gets its left operand
          we      = 1'b1;
          waddr   = raddr;
          wdata   = {e_op, 1'b1, mode_q ? e_val : v_q};
          state_d = S_FINAL;
        end else if (mode_q) begin
          emit = 1'b1;
          emit_data.postfix_symbol = e_val[7:0];
          if (out_free) begin
            v_d     = '0;
            level_d = level_m1;
            state_d = S_UNWIND;
          end
        end else if (e_op == OP_DIV && v_q == '0) begin
          err_d   = ST_DIV_ZERO;
          state_d = S_FINAL;
        end else if (e_op == OP_ADD || e_op == OP_SUB) begin
          v_d     = (e_op == OP_ADD) ? (e_val + v_q) : (e_val - v_q);
          level_d = level_m1;
          state_d = S_UNWIND;
        end else begin
          alu_req.start  = 1'b1;
          alu_req.is_div = (e_op == OP_DIV);
          state_d        = S_ARITH;
        end
      end
      S_ARITH: begin
        if (alu_done) begin
          v_d     = alu_res;
          level_d = level_m1;
          state_d = S_UNWIND;
        end
      end
      S_FINAL: begin
        if (end_q) begin
          emit           = 1'b1;
          emit_data.kind = 1'b1;
          emit_data.last = 1'b1;
          if (err_q != ST_OK) begin
            emit_data.status = err_q;
          end else if (!done_q && level_q != '0) begin
            emit_data.status = ST_INCOMPLETE;
          end else if (!mode_q && done_q) begin
            emit_data.value = val32;
          end
          if (out_free) begin
            level_d = '0;
            done_d  = 1'b0;
            err_d   = ST_OK;
            final_d = '0;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= 1'b0;
      level_q     <= '0;
      done_q      <= 1'b0;
      err_q       <= ST_OK;
      final_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      level_q <= level_d;
      done_q  <= done_d;
      err_q   <= err_d;
      final_q <= final_d;
      if (cfg_valid && cfg_ready) begin
        mode_q <= cfg_data_i;
      end
      if (emit && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    if (state_q == S_IDLE && in_valid) begin
      sym_q <= in_data_i.symbol;
      end_q <= in_data_i.end_of_expr;
    end
    if (emit && out_free) begin
      out_q <= emit_data;
    end
  end

  // stack level never runs past the memory
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= LW'(STACK_DEPTH))
    else $error("stack level out of range");

  // completion and error are exclusive within one expression
  a_done_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(done_q && err_q != ST_OK))
    else $error("expression both complete and failed");

  // the arithmetic unit is started only from the check step
  a_alu_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> state_q == S_CHECK && mode_q == 1'b0)
    else $error("arithmetic unit started out of sequence");

  // a delivered final item leaves a clean stack
  a_final_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINAL && end_q && out_free) |=>
      (level_q == '0 && !done_q && err_q == ST_OK))
    else $error("stack state not cleared after final item");

endmodule

@@ sim/tb_prefix_expression_evaluator_top.sv @@
`timescale 1ns / 1ps

module tb_prefix_expression_evaluator_top;
  import pee_pkg::*;

  localparam int DEPTH = 32;
  localparam logic [7:0] SYM_MINUS = 8'h2d;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int HOLD_AT = 100;         // symbols taken before the long hold-off
  localparam int HOLD_LEN = 600;
  localparam int QUIET_FROM = 200;      // no idling on either side in this
  localparam int QUIET_TO = 290;        // range of symbols taken
  localparam int DRAIN_CYCLES = 1200;   // lets the longest digit reduction finish

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;
  logic in_valid;
  logic in_stall;
  in_t in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  prefix_expression_evaluator_top u_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data_i(cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data_i (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data_o(out_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // requests waiting to be driven, results waiting to be seen
  in_t symbol_q[$];
  out_t result_q[$];

  // shadow of the evaluator state
  op_e pend_op[DEPTH];
  bit pend_left[DEPTH];
  logic [31:0] pend_val[DEPTH];
  int level;
  bit done;
  status_e err;
  logic [31:0] fin_val;
  bit mode;

  int cyc;
  int mismatches;
  int n_symbols;
  int n_results;
  int n_exprs;
  int n_postfix;
  int n_err_status;
  bit in_acc;

  function automatic void note_result(bit k, logic [7:0] s, logic [31:0] v,
                                      status_e st, bit l);
    out_t r;
    r.kind = k;
    r.postfix_symbol = s;
    r.value = v;
    r.status = st;
    r.last = l;
    result_q.push_back(r);
  endfunction

  function automatic logic [31:0] alu(op_e op, logic [31:0] a, logic [31:0] b);
    logic [31:0] q;
    case (op)
      OP_ADD: q = a + b;
      OP_SUB: q = a - b;
      OP_MUL: q = a * b;
      default: begin
        // most negative / -1 wraps back onto itself
        if (b == 32'hffff_ffff) q = 32'd0 - a;
        else q = $signed(a) / $signed(b);
      end
    endcase
    return q;
  endfunction

  function automatic void eval_symbol(in_t it);
    logic [31:0] v;
    bit busy;
    status_e st;
    logic [31:0] rv;
    int top;
    if (!done && err == ST_OK && it.symbol != SYM_NUL) begin
      if (it.symbol >= SYM_ZERO && it.symbol <= SYM_NINE) begin
        v = 32'(it.symbol - SYM_ZERO);
        if (mode) note_result(1'b0, it.symbol, '0, ST_OK, 1'b0);
        busy = 1'b1;
        while (busy) begin
          if (level == 0) begin
            done = 1'b1;
            fin_val = v;
            busy = 1'b0;
          end else begin
            top = level - 1;
            if (!pend_left[top]) begin
              pend_left[top] = 1'b1;
              if (!mode) pend_val[top] = v;
              busy = 1'b0;
            end else if (mode) begin
              note_result(1'b0, pend_val[top][7:0], '0, ST_OK, 1'b0);
              v = '0;
              level--;
            end else if (pend_op[top] == OP_DIV && v == '0) begin
              err = ST_DIV_ZERO;
              busy = 1'b0;
            end else begin
              v = alu(pend_op[top], pend_val[top], v);
              level--;
            end
          end
        end
      end else if (level >= DEPTH) begin
        err = ST_OVERFLOW;
      end else begin
        pend_op[level] = (it.symbol == SYM_PLUS) ? OP_ADD :
                         (it.symbol == SYM_MUL) ? OP_MUL :
                         (it.symbol == SYM_DIV) ? OP_DIV : OP_SUB;
        pend_left[level] = 1'b0;
        pend_val[level] = mode ? 32'(it.symbol) : '0;
        level++;
      end
    end
    if (it.end_of_expr) begin
      st = err;
      rv = '0;
      if (st == ST_OK && !done && level > 0) st = ST_INCOMPLETE;
      if (st == ST_OK && !mode && done) rv = fin_val;
      note_result(1'b1, SYM_NUL, rv, st, 1'b1);
      level = 0;
      done = 1'b0;
      err = ST_OK;
      fin_val = '0;
    end
  endfunction

  // stimulus builders
  function automatic void add_sym(logic [7:0] s, bit e);
    in_t it;
    it.symbol = s;
    it.end_of_expr = e;
    symbol_q.push_back(it);
  endfunction

  function automatic logic [7:0] rand_operator();
    logic [7:0] s;
    case ($urandom_range(0, 4))
      0: s = SYM_PLUS;
      1: s = SYM_MINUS;
      2: s = SYM_MUL;
      3: s = SYM_DIV;
      default: begin
        // any byte that is neither digit nor NUL; all but '+', '*' and '/' subtract
        do s = 8'($urandom_range(1, 255));
        while (s >= SYM_ZERO && s <= SYM_NINE);
      end
    endcase
    return s;
  endfunction

  // well-formed prefix expression, no end flag
  function automatic void add_expr(int max_ops);
    int need;
    int ops;
    need = 1;
    ops = 0;
    while (need > 0) begin
      if ($urandom_range(0, 19) == 0) add_sym(SYM_NUL, 1'b0);
      if (ops < max_ops && $urandom_range(0, 99) < 45) begin
        add_sym(rand_operator(), 1'b0);
        ops++;
        need++;
      end else begin
        add_sym(SYM_ZERO + 8'($urandom_range(0, 9)), 1'b0);
        need--;
      end
    end
  endfunction

  function automatic void close_expr();
    symbol_q[$].end_of_expr = 1'b1;
  endfunction

  function automatic void add_random_phase(int count);
    int start;
    int r;
    int cut;
    start = symbol_q.size();
    while (symbol_q.size() - start < count) begin
      r = $urandom_range(0, 99);
      if (r < 68) begin
        add_expr($urandom_range(1, 10));
        close_expr();
      end else if (r < 78) begin
        // truncated expression
        add_expr($urandom_range(2, 10));
        cut = $urandom_range(1, 3);
        while (cut > 0 && symbol_q.size() - start > 1) begin
          void'(symbol_q.pop_back());
          cut--;
        end
        close_expr();
      end else if (r < 87) begin
        // trailing symbols after a complete expression
        add_expr($urandom_range(0, 6));
        repeat ($urandom_range(1, 4)) add_sym(8'($urandom_range(0, 255)), 1'b0);
        close_expr();
      end else if (r < 95) begin
        repeat ($urandom_range(1, 6)) add_sym(8'($urandom_range(0, 255)), 1'b0);
        close_expr();
      end else if (r < 98) begin
        add_sym(SYM_NUL, 1'b1);
      end else begin
        // stack overflow, then a digit that must be ignored
        repeat (DEPTH + 1) add_sym(rand_operator(), 1'b0);
        add_sym(SYM_ZERO + 8'($urandom_range(0, 9)), 1'b1);
      end
    end
  endfunction

  // sampling at the rising edge: predict on request, check on result
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_acc <= 1'b0;
      cyc <= 0;
    end else begin
      cyc <= cyc + 1;
      in_acc <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        eval_symbol(in_data);
        n_symbols++;
      end
      if (out_valid && !out_stall) begin
        n_results++;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result %p at cycle %0d", out_data, cyc);
        end else begin
          if (out_data.kind !== result_q[0].kind
              || out_data.postfix_symbol !== result_q[0].postfix_symbol
              || out_data.value !== result_q[0].value
              || out_data.status !== result_q[0].status
              || out_data.last !== result_q[0].last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch at cycle %0d: expected %p, got %p",
                       cyc, result_q[0], out_data);
          end
          if (result_q[0].kind) begin
            n_exprs++;
            if (result_q[0].status != ST_OK) n_err_status++;
          end else begin
            n_postfix++;
          end
          void'(result_q.pop_front());
        end
      end
    end
  end

  function automatic bit idle_now();
    if (n_symbols >= QUIET_FROM && n_symbols < QUIET_TO) return 1'b0;
    return $urandom_range(0, 99) < 25;
  endfunction

  // sender: next symbol at the falling edge once the last one went in
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_acc)) begin
      if (symbol_q.size() == 0 || idle_now()) begin
        in_valid <= 1'b0;
      end else begin
        in_data <= symbol_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // receiver: random stall plus one long hold-off that backs up the input
  int hold_left = 0;
  bit held = 1'b0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (!held && n_symbols >= HOLD_AT) begin
        held <= 1'b1;
        hold_left <= HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_now();
      end
    end
  end

  // watchdog on cycles without any handshake
  int quiet_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_idle();
    while (symbol_q.size() != 0 || in_valid || result_q.size() != 0)
      @(posedge clk);
    // a trailing operator produces nothing, so let the sequencer settle
    repeat (40) @(posedge clk);
  endtask

  task automatic write_mode(bit m);
    @(negedge clk);
    cfg_data <= m;
    cfg_valid <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    mode = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  bit phase_mode[6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  initial begin
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    level = 0;
    done = 1'b0;
    err = ST_OK;
    fin_val = '0;
    mode = 1'b0;
    mismatches = 0;
    n_symbols = 0;
    n_results = 0;
    n_exprs = 0;
    n_postfix = 0;
    n_err_status = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int p = 0; p < 6; p++) begin
      wait_idle();
      write_mode(phase_mode[p]);
      if (p == 0) begin
        // directed: lone digit, add, other-symbol subtract, div by zero,
        // empty expression, most negative / -1
        add_sym(SYM_NINE, 1'b1);
        add_sym(SYM_PLUS, 1'b0);
        add_sym(SYM_NINE, 1'b0);
        add_sym(SYM_NINE, 1'b1);
        add_sym(8'hff, 1'b0);
        add_sym(SYM_ZERO, 1'b0);
        add_sym(SYM_NINE, 1'b1);
        add_sym(SYM_DIV, 1'b0);
        add_sym(SYM_NINE, 1'b0);
        add_sym(SYM_ZERO, 1'b1);
        add_sym(SYM_NUL, 1'b1);
        add_sym(SYM_DIV, 1'b0);
        add_sym(SYM_MINUS, 1'b0);
        add_sym(SYM_ZERO, 1'b0);
        add_sym(SYM_MUL, 1'b0);
        add_sym(SYM_ZERO + 8'd2, 1'b0);
        repeat (9) add_sym(SYM_MUL, 1'b0);
        repeat (10) add_sym(SYM_ZERO + 8'd8, 1'b0);
        add_sym(SYM_MINUS, 1'b0);
        add_sym(SYM_ZERO, 1'b0);
        add_sym(SYM_ZERO + 8'd1, 1'b1);
        add_random_phase(20);
      end else begin
        add_random_phase(62);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d symbols sent, %0d results checked (%0d postfix symbols)",
             n_symbols, n_results, n_postfix);
    $display("%0d expressions closed in both modes, %0d with error status",
             n_exprs, n_err_status);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, result_q.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
